@@ rtl/orbit_true_anomaly_stepper_macros.svh @@
// ---------------------------------------------------------------------------
// orbit true anomaly stepper assertion macros
// shared concurrent assertion forms used by the controller and the datapath
// ---------------------------------------------------------------------------
`ifndef ORBIT_TRUE_ANOMALY_STEPPER_MACROS_SVH
`define ORBIT_TRUE_ANOMALY_STEPPER_MACROS_SVH

// same-cycle implication
`define OTAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OTAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/otas_pkg.sv @@
// ---------------------------------------------------------------------------
// otas_pkg
// types, constants and tables shared by the orbit true anomaly stepper
// ---------------------------------------------------------------------------
package otas_pkg;

    localparam int GRID_SPAN_DEF    = 30;
    localparam int CORDIC_STEPS_DEF = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ECC     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_MOM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TSTEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERI    = 3'd4;

    localparam logic [15:0] ECC_RST     = 16'd39322;
    localparam logic [23:0] ANG_MOM_RST = 24'd655360;
    localparam logic [23:0] GRAV_RST    = 24'd1310720;
    localparam logic [19:0] TSTEP_RST   = 20'd26214;
    localparam logic [31:0] PERI_RST    = 32'd786403627;

    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
    localparam logic [29:0]        TURN_PER_RAD = 30'd683565276;

    // quotient lengths of the three divisions
    localparam int T_BITS = 48;
    localparam int R_BITS = 32;
    localparam int U_BITS = 24;

    typedef struct packed {
        logic advance;
    } t_in_item;

    typedef struct packed {
        logic [31:0] distance;
        logic [31:0] anomaly;
        logic [4:0]  grid_x;
        logic [4:0]  grid_y;
        logic        on_grid;
    } t_out_item;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CORD_INIT_A,
        OP_CORD_INIT_B,
        OP_CORD_STEP,
        OP_CORD_END,
        OP_DEN,
        OP_DIV_T_INIT,
        OP_DIV_STEP,
        OP_DIV_R_INIT,
        OP_R_TAKE,
        OP_R_SAT,
        OP_GRID_X,
        OP_GRID_Y,
        OP_GRID_FIN,
        OP_SQUARE,
        OP_DIV_U_INIT,
        OP_DA,
        OP_DA_SAT,
        OP_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [4:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic r_bad;
        logic t_sat;
        logic r_zero;
        logic u_over;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            5'd31: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/otas_chan.sv @@
// ---------------------------------------------------------------------------
// otas_chan
// valid/ready channel carrying one payload beat
// ---------------------------------------------------------------------------
interface otas_chan #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/otas_ctrl.sv @@
// ---------------------------------------------------------------------------
// otas_ctrl
// sequencer for one tick: cordic, divisions, grid fold and anomaly step
// ---------------------------------------------------------------------------
`include "orbit_true_anomaly_stepper_macros.svh"

module otas_ctrl #(
    parameter int CORDIC_STEPS = otas_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    otas_chan.sink             i_in_ch,
    input  otas_pkg::t_dp_stat i_stat,
    output otas_pkg::t_dp_cmd  o_cmd
);
    import otas_pkg::*;

    localparam int CNT_W = $clog2(T_BITS);
    localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] T_LAST    = CNT_W'(T_BITS - 1);
    localparam logic [CNT_W-1:0] R_LAST    = CNT_W'(R_BITS - 1);
    localparam logic [CNT_W-1:0] U_LAST    = CNT_W'(U_BITS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_C1_INIT, S_C1_RUN, S_C1_END, S_DEN, S_T_INIT, S_T_RUN, S_T_CHK,
        S_R_INIT, S_R_RUN, S_R_TAKE, S_R_SAT, S_C2_INIT, S_C2_RUN, S_C2_END,
        S_GRID_X, S_GRID_Y, S_GRID_FIN, S_SQUARE, S_U_CHK, S_U_INIT, S_U_RUN,
        S_DA, S_DA_SAT, S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_dp_op           op;

    assign i_in_ch.ready = (r_state == S_IDLE);
    assign o_cmd.op      = op;
    assign o_cmd.idx     = r_cnt[4:0];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        op      = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_ch.valid && i_in_ch.data.advance) n_state = S_C1_INIT;
            end
            S_C1_INIT: begin
                op = OP_CORD_INIT_A; n_cnt = '0; n_state = S_C1_RUN;
            end
            S_C1_RUN: begin
                op = OP_CORD_STEP;
                if (r_cnt == CORD_LAST) n_state = S_C1_END;
                else n_cnt = r_cnt + 1'b1;
            end
            S_C1_END: begin
                op = OP_CORD_END; n_state = S_DEN;
            end
            S_DEN: begin
                op = OP_DEN; n_state = S_T_INIT;
            end
            S_T_INIT: begin
                op = OP_DIV_T_INIT; n_cnt = '0;
                n_state = i_stat.r_bad ? S_R_SAT : S_T_RUN;
            end
            S_T_RUN: begin
                op = OP_DIV_STEP;
                if (r_cnt == T_LAST) n_state = S_T_CHK;
                else n_cnt = r_cnt + 1'b1;
            end
            S_T_CHK: begin
                n_state = i_stat.t_sat ? S_R_SAT : S_R_INIT;
            end
            S_R_INIT: begin
                op = OP_DIV_R_INIT; n_cnt = '0; n_state = S_R_RUN;
            end
            S_R_RUN: begin
                op = OP_DIV_STEP;
                if (r_cnt == R_LAST) n_state = S_R_TAKE;
                else n_cnt = r_cnt + 1'b1;
            end
            S_R_TAKE: begin
                op = OP_R_TAKE; n_state = S_C2_INIT;
            end
            S_R_SAT: begin
                op = OP_R_SAT; n_state = S_C2_INIT;
            end
            S_C2_INIT: begin
                op = OP_CORD_INIT_B; n_cnt = '0; n_state = S_C2_RUN;
            end
            S_C2_RUN: begin
                op = OP_CORD_STEP;
                if (r_cnt == CORD_LAST) n_state = S_C2_END;
                else n_cnt = r_cnt + 1'b1;
            end
            S_C2_END: begin
                op = OP_CORD_END; n_state = S_GRID_X;
            end
            S_GRID_X: begin
                op = OP_GRID_X; n_state = S_GRID_Y;
            end
            S_GRID_Y: begin
                op = OP_GRID_Y; n_state = S_GRID_FIN;
            end
            S_GRID_FIN: begin
                op = OP_GRID_FIN;
                n_state = i_stat.r_zero ? S_FIN : S_SQUARE;
            end
            S_SQUARE: begin
                op = OP_SQUARE; n_state = S_U_CHK;
            end
            S_U_CHK: begin
                n_state = i_stat.u_over ? S_DA_SAT : S_U_INIT;
            end
            S_U_INIT: begin
                op = OP_DIV_U_INIT; n_cnt = '0; n_state = S_U_RUN;
            end
            S_U_RUN: begin
                op = OP_DIV_STEP;
                if (r_cnt == U_LAST) n_state = S_DA;
                else n_cnt = r_cnt + 1'b1;
            end
            S_DA: begin
                op = OP_DA; n_state = S_FIN;
            end
            S_DA_SAT: begin
                op = OP_DA_SAT; n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    op = OP_FIN; n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `OTAS_ASSERT_NOW(a_div_cnt, i_clk, i_rst_n, r_state == S_T_RUN, r_cnt <= T_LAST, "divider count overrun")
    `OTAS_ASSERT_NOW(a_cord_cnt, i_clk, i_rst_n, r_state == S_C1_RUN || r_state == S_C2_RUN, r_cnt <= CORD_LAST, "cordic count overrun")
    `OTAS_ASSERT_NEXT(a_fin_idle, i_clk, i_rst_n, op == OP_FIN, r_state == S_IDLE, "no return to idle after result")

endmodule

@@ rtl/otas_dpath.sv @@
// ---------------------------------------------------------------------------
// otas_dpath
// configuration, anomaly state, shared cordic, bit-serial divider,
// multipliers and the output register
// ---------------------------------------------------------------------------
`include "orbit_true_anomaly_stepper_macros.svh"

module otas_dpath #(
    parameter int GRID_SPAN = otas_pkg::GRID_SPAN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [otas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [otas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  otas_pkg::t_dp_cmd               i_cmd,
    output otas_pkg::t_dp_stat              o_stat,
    otas_chan.source                        o_out_ch
);
    import otas_pkg::*;

    localparam logic signed [67:0] CENTER_OFS = 68'(GRID_SPAN / 2) <<< 46;
    localparam logic signed [67:0] HALF_M1    = (68'sd1 <<< 45) - 68'sd1;
    localparam logic signed [21:0] SPAN_G     = 22'(GRID_SPAN);

    // configuration and anomaly state
    logic [15:0] r_ecc;
    logic [23:0] r_h, r_mu;
    logic [19:0] r_dt;
    logic [31:0] r_peri, r_th;

    // working registers
    logic signed [33:0] r_x, r_y, r_z, r_c, r_s, r_den;
    logic [1:0]         r_q;
    logic [63:0]        r_rem, r_div, r_rr;
    logic [47:0]        r_low, r_quo;
    logic [31:0]        r_r, r_da;
    logic signed [66:0] r_prod;
    logic [4:0]         r_gx, r_gy;
    logic               r_gx_in, r_gy_in;
    logic [43:0]        r_p;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [31:0]        cord_ang, cord_sum, cord_d;
    logic [1:0]         cord_q;
    logic signed [33:0] xs, ys, at;
    logic [64:0]        rem2, diff;
    logic               ge;
    logic signed [50:0] ec;
    logic signed [33:0] den_n;
    logic [47:0]        hh;
    logic signed [33:0] g_src;
    logic signed [66:0] prod_n;
    logic signed [67:0] g_v;
    logic signed [21:0] g;
    logic [4:0]         g_cl;
    logic               g_in;
    logic [63:0]        rr_n;
    logic [43:0]        p_n;
    logic [23:0]        u;
    logic [53:0]        u_mul;
    logic [34:0]        u_sh;
    logic [31:0]        da_n;

    assign cord_ang = (i_cmd.op == OP_CORD_INIT_B) ? r_th + r_peri : r_th;
    assign cord_sum = cord_ang + 32'h2000_0000;
    assign cord_q   = cord_sum[31:30];
    assign cord_d   = cord_ang - {cord_q, 30'b0};

    assign xs = r_x >>> i_cmd.idx;
    assign ys = r_y >>> i_cmd.idx;
    assign at = $signed({4'b0, atan_entry(i_cmd.idx)});

    assign rem2 = {r_rem, r_low[47]};
    assign ge   = rem2 >= {1'b0, r_div};
    assign diff = rem2 - {1'b0, r_div};

    assign ec    = $signed({1'b0, r_ecc}) * r_c;
    assign den_n = ONE_Q30 + 34'(ec >>> 16);
    assign hh    = r_h * r_h;

    assign g_src  = (i_cmd.op == OP_GRID_X) ? r_c : r_s;
    assign prod_n = $signed({1'b0, r_r}) * g_src;
    assign g_v    = 68'(r_prod) + CENTER_OFS + HALF_M1;
    assign g      = g_v[67:46];
    assign g_in   = (g >= 0) && (g <= SPAN_G);
    always_comb begin
        g_cl = g[4:0];
        if (g < 0) g_cl = '0;
        else if (g > SPAN_G) g_cl = SPAN_G[4:0];
    end

    assign rr_n = r_r * r_r;
    assign p_n  = r_dt * r_h;

    assign u     = r_quo[23:0];
    assign u_mul = u * TURN_PER_RAD;
    assign u_sh  = u_mul[53:19];
    assign da_n  = (u > 24'h80_0000 || u_sh[34:32] != 3'b0) ? 32'hFFFF_FFFF : u_sh[31:0];

    assign o_stat.r_bad    = (r_mu == '0) || (r_den <= 0);
    assign o_stat.t_sat    = r_quo >= {13'b0, r_den[32:0], 2'b00};
    assign o_stat.r_zero   = (r_r == '0);
    assign o_stat.u_over   = {25'b0, r_p[43:5]} >= r_rr;
    assign o_stat.out_busy = r_out_valid && !o_out_ch.ready;

    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;

    // control state: configuration, anomaly, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecc       <= ECC_RST;
            r_h         <= ANG_MOM_RST;
            r_mu        <= GRAV_RST;
            r_dt        <= TSTEP_RST;
            r_peri      <= PERI_RST;
            r_th        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ECC:     r_ecc  <= i_cfg_data[15:0];
                    CFG_ANG_MOM: r_h    <= i_cfg_data[23:0];
                    CFG_GRAV:    r_mu   <= i_cfg_data[23:0];
                    CFG_TSTEP:   r_dt   <= i_cfg_data[19:0];
                    CFG_PERI:    r_peri <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && o_out_ch.ready) r_out_valid <= 1'b0;
            if (i_cmd.op == OP_FIN) begin
                r_out_valid <= 1'b1;
                if (r_r != '0) r_th <= r_th + r_da;
            end
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CORD_INIT_A, OP_CORD_INIT_B: begin
                r_x <= CORDIC_GAIN;
                r_y <= '0;
                r_z <= 34'($signed(cord_d));
                r_q <= cord_q;
            end
            OP_CORD_STEP: begin
                if (!r_z[33]) begin
                    r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + at;
                end
            end
            OP_CORD_END: begin
                unique case (r_q)
                    2'd0: begin r_c <= r_x;  r_s <= r_y;  end
                    2'd1: begin r_c <= -r_y; r_s <= r_x;  end
                    2'd2: begin r_c <= -r_x; r_s <= -r_y; end
                    2'd3: begin r_c <= r_y;  r_s <= -r_x; end
                endcase
            end
            OP_DEN: r_den <= den_n;
            OP_DIV_T_INIT: begin
                r_rem <= '0;
                r_low <= hh;
                r_div <= {40'b0, r_mu};
                r_quo <= '0;
            end
            OP_DIV_R_INIT: begin
                r_rem <= {18'b0, r_quo[47:2]};
                r_low <= {r_quo[1:0], 46'b0};
                r_div <= {31'b0, r_den[32:0]};
                r_quo <= '0;
            end
            OP_DIV_U_INIT: begin
                r_rem <= {25'b0, r_p[43:5]};
                r_low <= {r_p[4:0], 43'b0};
                r_div <= r_rr;
                r_quo <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= ge ? diff[63:0] : rem2[63:0];
                r_low <= {r_low[46:0], 1'b0};
                r_quo <= {r_quo[46:0], ge};
            end
            OP_R_TAKE: r_r <= r_quo[31:0];
            OP_R_SAT:  r_r <= 32'hFFFF_FFFF;
            OP_GRID_X: r_prod <= prod_n;
            OP_GRID_Y: begin
                r_prod  <= prod_n;
                r_gx    <= g_cl;
                r_gx_in <= g_in;
            end
            OP_GRID_FIN: begin
                r_gy    <= g_cl;
                r_gy_in <= g_in;
            end
            OP_SQUARE: begin
                r_rr <= rr_n;
                r_p  <= p_n;
            end
            OP_DA:     r_da <= da_n;
            OP_DA_SAT: r_da <= 32'hFFFF_FFFF;
            OP_FIN: begin
                r_out.distance <= r_r;
                r_out.anomaly  <= r_th;
                r_out.grid_x   <= r_gx;
                r_out.grid_y   <= r_gy;
                r_out.on_grid  <= r_gx_in && r_gy_in;
            end
            OP_NOP: ;
        endcase
    end

    `OTAS_ASSERT_NOW(a_r_fits, i_clk, i_rst_n, i_cmd.op == OP_R_TAKE, r_quo[47:32] == 16'b0, "distance quotient overflow")
    `OTAS_ASSERT_NEXT(a_th_hold, i_clk, i_rst_n, i_cmd.op != OP_FIN, $stable(r_th), "anomaly moved outside result beat")
    `OTAS_ASSERT_NOW(a_valid_src, i_clk, i_rst_n, $rose(r_out_valid), $past(i_cmd.op) == OP_FIN, "result beat without finish")

endmodule

@@ rtl/orbit_true_anomaly_stepper.sv @@
// ---------------------------------------------------------------------------
// orbit_true_anomaly_stepper
// two-body orbit point report and euler step of the true anomaly
// ---------------------------------------------------------------------------
// Each accepted beat with advance set yields one result beat (distance,
// anomaly before the step, grid point, on-grid flag) and then advances the
// anomaly unless the distance is zero; a beat with advance clear is taken
// and ignored. An item finishes sooner when the distance or the step
// saturates; its time is set by the shared cordic unit, run twice at one
// iteration per cycle, and by the shared restoring divider, which produces
// one quotient bit per cycle for 48, 32 and 24 bits. A new item is taken
// once the previous one has reached the output register.
module orbit_true_anomaly_stepper #(
    parameter int GRID_SPAN    = otas_pkg::GRID_SPAN_DEF,
    parameter int CORDIC_STEPS = otas_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    otas_chan.sink                          i_in_ch,
    otas_chan.source                        o_out_ch,
    input  logic                            i_cfg_we,
    input  logic [otas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [otas_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import otas_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    otas_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (i_in_ch),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    otas_dpath #(
        .GRID_SPAN (GRID_SPAN)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_ch   (o_out_ch)
    );

endmodule
